FILE: design/lrfg_pkg.sv
// shared constants, neighbour graph and helper functions for the life rule block
package lrfg_pkg;

  // fixed widths of the item fields
  localparam int PATTERN_W = 21;

  // defaults for the top-level parameters
  localparam int DEF_NUM_CELLS     = 21;
  localparam int DEF_MAX_NEIGHBORS = 10;

  // request codes
  localparam logic REQ_LOAD    = 1'b0;
  localparam logic REQ_ADVANCE = 1'b1;

  // pattern after reset: cells 3, 4 and 5 live
  localparam logic [63:0] RESET_PATTERN = 64'h38;

  // built-in irregular graph
  localparam int GRAPH_ROWS = 21;
  localparam int FLAT_LEN   = 180;

  localparam int NBR_COUNT [GRAPH_ROWS] = '{
    10, 8, 8, 8, 8, 8, 10, 10, 10, 10, 10, 9, 9, 9, 9, 9, 7, 7, 7, 7, 7
  };

  localparam int NBR_FLAT [FLAT_LEN] = '{
    1, 2, 3, 4, 5, 6, 7, 8, 9, 10,
    0, 2, 5, 6, 7, 11, 12, 17,
    0, 1, 3, 7, 8, 12, 13, 18,
    0, 2, 4, 8, 9, 13, 14, 19,
    0, 3, 5, 9, 10, 14, 15, 20,
    0, 1, 4, 6, 10, 11, 15, 16,
    0, 1, 5, 7, 10, 11, 12, 15, 16, 17,
    0, 1, 2, 6, 8, 11, 12, 13, 17, 18,
    0, 2, 3, 7, 9, 12, 13, 14, 18, 19,
    0, 3, 4, 8, 10, 13, 14, 15, 19, 20,
    0, 4, 5, 6, 9, 11, 14, 15, 16, 20,
    1, 5, 6, 7, 10, 12, 15, 16, 17,
    1, 2, 6, 7, 8, 11, 13, 17, 18,
    2, 3, 7, 8, 9, 12, 14, 18, 19,
    3, 4, 8, 9, 10, 13, 15, 19, 20,
    4, 5, 6, 9, 10, 11, 14, 16, 20,
    5, 6, 10, 11, 15, 17, 20,
    1, 6, 7, 11, 12, 16, 18,
    2, 7, 8, 12, 13, 17, 19,
    3, 8, 9, 13, 14, 18, 20,
    4, 9, 10, 14, 15, 16, 19
  };

  // update strobes from the handshake control to the row of cells
  typedef struct packed {
    logic load;
    logic advance;
  } upd_t;

  // neighbour set of one cell as a bit mask, first max_nbr list entries only
  function automatic logic [63:0] nbr_mask(input int cell_idx, input int max_nbr);
    logic [63:0] m;
    int          base;
    m    = '0;
    base = 0;
    for (int r = 0; r < GRAPH_ROWS; r++) begin
      if (r == cell_idx) begin
        for (int j = 0; j < NBR_COUNT[r]; j++) begin
          if (j < max_nbr) begin
            m[NBR_FLAT[base + j]] = 1'b1;
          end
        end
      end
      base += NBR_COUNT[r];
    end
    return m;
  endfunction

  // bits of the result that map onto existing cells
  function automatic logic [PATTERN_W-1:0] out_mask(input int num_cells);
    logic [PATTERN_W-1:0] m;
    m = '0;
    for (int k = 0; k < PATTERN_W; k++) begin
      if (k < num_cells) begin
        m[k] = 1'b1;
      end
    end
    return m;
  endfunction

endpackage

FILE: design/life_rule_on_fixed_graph_unit.sv
// top level: handshake control and the row of life cells
//
// Life rule (born on three, survives on two or three) over a fixed graph of
// NUM_CELLS cells with a built-in neighbour table.
// Request channel: req_valid / req_stall carry req_type and load_pattern.
// A load item (req_type 0) replaces the pattern; an advance item (req_type 1)
// computes the next generation of every cell at once.
// Result channel: res_valid / res_stall carry cell_states, the pattern after
// the item, one result per item.
// The result is shown in the cycle after the item is taken.
// Throughput: one item per cycle while no stalled result is pending; every cell
// evaluates its neighbour count in parallel, so the rate is set by the cell registers alone.
// The cell registers are the result register: a new item is taken while the
// held result is being taken in the same cycle.
// When the receiver stalls with a result pending, req_stall rises and the
// pattern holds until the result is taken.
// Reset: the result channel empties and cells 3, 4 and 5 become live.
module life_rule_on_fixed_graph_unit
  import lrfg_pkg::*;
#(
  parameter int NUM_CELLS     = DEF_NUM_CELLS,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic                 req_type,
  input  logic [PATTERN_W-1:0] load_pattern,
  output logic                 res_valid,
  input  logic                 res_stall,
  output logic [PATTERN_W-1:0] cell_states
);

  logic                 accept;
  logic                 res_valid_next;
  upd_t                 upd;
  logic [NUM_CELLS-1:0] live;
  logic [NUM_CELLS-1:0] load_bits;

  // handshake: hold off while a result is pending and stalled
  assign req_stall = res_valid && res_stall;
  assign accept    = req_valid && !req_stall;

  assign upd.load    = accept && (req_type == REQ_LOAD);
  assign upd.advance = accept && (req_type == REQ_ADVANCE);

  always_comb begin
    if (accept) begin
      res_valid_next = 1'b1;
    end else if (!res_stall) begin
      res_valid_next = 1'b0;
    end else begin
      res_valid_next = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= res_valid_next;
    end
  end

  // row of cells
  for (genvar c = 0; c < NUM_CELLS; c++) begin : g_cell
    if (c < PATTERN_W) begin : g_ld
      assign load_bits[c] = load_pattern[c];
    end else begin : g_zero
      assign load_bits[c] = 1'b0;
    end

    lrfg_cell #(
      .NUM_CELLS     (NUM_CELLS),
      .MAX_NEIGHBORS (MAX_NEIGHBORS),
      .CELL_IDX      (c)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .upd      (upd),
      .load_bit (load_bits[c]),
      .state    (live),
      .live     (live[c])
    );
  end

  // result: low pattern bits of the cell registers
  for (genvar k = 0; k < PATTERN_W; k++) begin : g_out
    if (k < NUM_CELLS) begin : g_cell_bit
      assign cell_states[k] = live[k];
    end else begin : g_none
      assign cell_states[k] = 1'b0;
    end
  end

endmodule

FILE: design/lrfg_cell.sv
// one cell of the row: holds its live bit and applies the b3/s23 rule
module lrfg_cell
  import lrfg_pkg::*;
#(
  parameter int NUM_CELLS     = DEF_NUM_CELLS,
  parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
  parameter int CELL_IDX      = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  upd_t                 upd,
  input  logic                 load_bit,
  input  logic [NUM_CELLS-1:0] state,
  output logic                 live
);

  localparam logic [63:0] MASK    = nbr_mask(CELL_IDX, MAX_NEIGHBORS);
  localparam logic        RST_BIT = RESET_PATTERN[CELL_IDX];
  localparam int CNT_RAW = $clog2(MAX_NEIGHBORS + 1);
  localparam int CNT_W   = (CNT_RAW < 2) ? 2 : CNT_RAW;

  logic [CNT_W-1:0] cnt;
  logic             live_next;

  // live neighbours; entries at or above NUM_CELLS are outside the block
  always_comb begin
    cnt = '0;
    for (int i = 0; i < NUM_CELLS; i++) begin
      if (MASK[i]) begin
        cnt = cnt + CNT_W'(state[i]);
      end
    end
  end

  // survive on two or three, birth on exactly three
  always_comb begin
    if (live) begin
      live_next = (cnt == CNT_W'(2)) || (cnt == CNT_W'(3));
    end else begin
      live_next = (cnt == CNT_W'(3));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= RST_BIT;
    end else if (upd.load) begin
      live <= load_bit;
    end else if (upd.advance) begin
      live <= live_next;
    end
  end

endmodule

FILE: design/lrfg_checker.sv
// port-level checks for the life rule block and their bind
module lrfg_checker
  import lrfg_pkg::*;
#(
  parameter int NUM_CELLS = DEF_NUM_CELLS
) (
  input logic                 clk,
  input logic                 rst,
  input logic                 req_valid,
  input logic                 req_stall,
  input logic                 req_type,
  input logic [PATTERN_W-1:0] load_pattern,
  input logic                 res_valid,
  input logic                 res_stall,
  input logic [PATTERN_W-1:0] cell_states
);

  localparam logic [PATTERN_W-1:0] VIS_MASK = out_mask(NUM_CELLS);

  // request side is held off exactly when a result waits stalled
  a_stall_rule: assert property (@(posedge clk) disable iff (rst)
    req_stall == (res_valid && res_stall))
    else $error("req_stall does not follow the pending result");

  // every item taken shows a result next cycle
  a_item_result: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall) |=> res_valid)
    else $error("item taken without a result");

  // a result taken with no new item leaves the channel empty
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_stall && !(req_valid && !req_stall)) |=> !res_valid)
    else $error("result shown twice");

  // a load item returns the loaded pattern
  a_load_echo: assert property (@(posedge clk) disable iff (rst)
    (req_valid && !req_stall && (req_type == REQ_LOAD))
      |=> cell_states == ($past(load_pattern) & VIS_MASK))
    else $error("loaded pattern not returned");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_stall) |=> (res_valid && $stable(cell_states)))
    else $error("stalled result changed");

endmodule

bind life_rule_on_fixed_graph_unit lrfg_checker #(
  .NUM_CELLS (NUM_CELLS)
) u_lrfg_checker (
  .clk          (clk),
  .rst          (rst),
  .req_valid    (req_valid),
  .req_stall    (req_stall),
  .req_type     (req_type),
  .load_pattern (load_pattern),
  .res_valid    (res_valid),
  .res_stall    (res_stall),
  .cell_states  (cell_states)
);
